/* src/rectangle_subtract_pieces_macros.svh */
// Assertion macros for the verification files of rectangle_subtract_pieces.
// Needs clk and rst_n in scope where a macro is used.
`ifndef RECTANGLE_SUBTRACT_PIECES_MACROS_SVH
`define RECTANGLE_SUBTRACT_PIECES_MACROS_SVH

// same-cycle implication, silent during reset
`define RSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsp check failed");

// next-cycle implication, silent during reset
`define RSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsp check failed");

`endif

/* src/rsp_pkg.sv */
// Types shared by the rectangle subtraction block: input item, piece, piece set.
// No dependencies.
package rsp_pkg;

    localparam int NumSides = 4;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_LEFT   = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [15:0] cover_x;
        logic signed [15:0] cover_y;
        logic [14:0]        cover_w;
        logic [14:0]        cover_h;
        logic signed [15:0] area_x;
        logic signed [15:0] area_y;
        logic [14:0]        area_w;
        logic [14:0]        area_h;
    } item_t;

    typedef struct packed {
        logic [1:0]         side;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } piece_t;

    typedef struct packed {
        logic                       overlap;
        logic                       piece_valid;
        logic [NumSides-1:0]        mask;
        piece_t [NumSides-1:0]      pieces;
    } piece_set_t;

endpackage

/* src/rsp_split.sv */
// Splits the area rectangle around the cover rectangle into up to four pieces.
// Depends on rsp_pkg.
module rsp_split (
    input  rsp_pkg::item_t      item,
    output rsp_pkg::piece_set_t set
);
    import rsp_pkg::*;

    // edges at 18 bits so sums never wrap
    logic signed [17:0] cx, cy, cr, cb, ax, ay, ar, ab;
    logic signed [17:0] my, mb, mh;
    logic               hit;
    logic [NumSides-1:0] have;

    always_comb
    begin
        cx = {{2{item.cover_x[15]}}, item.cover_x};
        cy = {{2{item.cover_y[15]}}, item.cover_y};
        ax = {{2{item.area_x[15]}}, item.area_x};
        ay = {{2{item.area_y[15]}}, item.area_y};
        cr = cx + $signed({3'b000, item.cover_w});
        cb = cy + $signed({3'b000, item.cover_h});
        ar = ax + $signed({3'b000, item.area_w});
        ab = ay + $signed({3'b000, item.area_h});

        hit = (cx < ar) && (cr > ax) && (cy < ab) && (cb > ay);

        have[SIDE_TOP]    = cy > ay;
        have[SIDE_LEFT]   = cx > ax;
        have[SIDE_RIGHT]  = cr < ar;
        have[SIDE_BOTTOM] = cb < ab;

        // rows shared by both rectangles
        my = (cy > ay) ? cy : ay;
        mb = (cb < ab) ? cb : ab;
        mh = mb - my;

        set.pieces[SIDE_TOP]    = '{SIDE_TOP, item.area_x, item.area_y, item.area_w,
                                    15'(cy - ay)};
        set.pieces[SIDE_LEFT]   = '{SIDE_LEFT, item.area_x, my[15:0], 15'(cx - ax),
                                    mh[14:0]};
        set.pieces[SIDE_RIGHT]  = '{SIDE_RIGHT, cr[15:0], my[15:0], 15'(ar - cr),
                                    mh[14:0]};
        set.pieces[SIDE_BOTTOM] = '{SIDE_BOTTOM, item.area_x, cb[15:0], item.area_w,
                                    15'(ab - cb)};
        set.overlap     = hit;
        set.piece_valid = 1'b1;
        set.mask        = have;

        if (!hit)
        begin
            // echo the area untouched
            set.pieces[SIDE_TOP] = '{SIDE_TOP, item.area_x, item.area_y, item.area_w,
                                     item.area_h};
            set.mask = 4'b0001;
        end
        else if (have == '0)
        begin
            // fully covered: one empty beat
            set.pieces[SIDE_TOP] = '0;
            set.piece_valid      = 1'b0;
            set.mask             = 4'b0001;
        end
    end

endmodule

/* src/rectangle_subtract_pieces.sv */
// Top level of the rectangle subtraction block: input register, splitter, piece bank.
// Depends on rsp_pkg and rsp_split.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  command  | start / busy         | cover_x/y/w/h, area_x/y/w/h
//  result   | strobe (no stall)    | overlap, piece_valid, piece_side,
//           |                      | piece_x/y/w/h, last
//
// An item waits in the input register until the piece bank is free; its pieces then
// leave the bank one per cycle over the single result port, 1 to 4 beats per item.
// Busy is high while an item waits and the bank still has more than one beat to send.
// Reset clears the valid flag and the bank mask; payload registers are not reset.
// An accepted item passes the input register and then the piece bank before its first beat.
module rectangle_subtract_pieces (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] cover_x,
    input  logic signed [15:0] cover_y,
    input  logic [14:0]        cover_w,
    input  logic [14:0]        cover_h,
    input  logic signed [15:0] area_x,
    input  logic signed [15:0] area_y,
    input  logic [14:0]        area_w,
    input  logic [14:0]        area_h,
    output logic               strobe,
    output logic               overlap,
    output logic               piece_valid,
    output logic [1:0]         piece_side,
    output logic signed [15:0] piece_x,
    output logic signed [15:0] piece_y,
    output logic [14:0]        piece_w,
    output logic [14:0]        piece_h,
    output logic               last
);
    import rsp_pkg::*;

    item_t               item_reg;
    logic                in_valid_reg, in_valid_next;
    logic [NumSides-1:0] mask_reg, mask_next;
    logic                overlap_reg, piece_valid_reg;
    piece_t [NumSides-1:0] pieces_reg;

    piece_set_t          split_set;
    logic [NumSides-1:0] rest;
    logic                bank_free, load_bank, accept;
    logic [1:0]          sel;
    piece_t              cur;

    rsp_split u_split (
        .item (item_reg),
        .set  (split_set)
    );

    always_comb
    begin
        rest      = mask_reg & (mask_reg - 4'd1);
        bank_free = (rest == '0);
        load_bank = in_valid_reg && bank_free;
        busy      = in_valid_reg && !bank_free;
        accept    = start && !busy;

        in_valid_next = accept ? 1'b1 : (load_bank ? 1'b0 : in_valid_reg);
        mask_next     = load_bank ? split_set.mask : rest;

        // lowest pending side goes out first
        sel = SIDE_BOTTOM;
        if (mask_reg[SIDE_RIGHT])  sel = SIDE_RIGHT;
        if (mask_reg[SIDE_LEFT])   sel = SIDE_LEFT;
        if (mask_reg[SIDE_TOP])    sel = SIDE_TOP;
        cur = pieces_reg[sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mask_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{cover_x, cover_y, cover_w, cover_h,
                          area_x, area_y, area_w, area_h};
        end
        if (load_bank)
        begin
            pieces_reg      <= split_set.pieces;
            overlap_reg     <= split_set.overlap;
            piece_valid_reg <= split_set.piece_valid;
        end
    end

    assign strobe      = |mask_reg;
    assign overlap     = overlap_reg;
    assign piece_valid = piece_valid_reg;
    assign piece_side  = cur.side;
    assign piece_x     = cur.x;
    assign piece_y     = cur.y;
    assign piece_w     = cur.w;
    assign piece_h     = cur.h;
    assign last        = strobe && bank_free;

endmodule

/* src/rsp_checker.sv */
// Port-level checks for rectangle_subtract_pieces, bound to the top level.
// Depends on rsp_pkg and rectangle_subtract_pieces_macros.svh.
`include "rectangle_subtract_pieces_macros.svh"

module rsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic       overlap,
    input logic       piece_valid,
    input logic [1:0] piece_side,
    input logic       last
);
    import rsp_pkg::*;

    // pieces of one item leave in consecutive cycles
    `RSP_ASSERT_NEXT(a_run_contiguous, strobe && !last, strobe)
    // sides ascend within one item
    `RSP_ASSERT_NEXT(a_side_order, strobe && !last, piece_side > $past(piece_side))
    // an empty beat is the only beat of a fully covered item
    `RSP_ASSERT_NOW(a_empty_alone, strobe && !piece_valid, last && overlap)
    // a miss echoes the area in one beat
    `RSP_ASSERT_NOW(a_miss_single, strobe && !overlap,
                    last && piece_valid && (piece_side == SIDE_TOP))

endmodule

bind rectangle_subtract_pieces rsp_checker u_rsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .strobe      (strobe),
    .overlap     (overlap),
    .piece_valid (piece_valid),
    .piece_side  (piece_side),
    .last        (last)
);

/* sim/testbench.sv */
// Self-checking testbench for rectangle_subtract_pieces: directed and random cover/area pairs.
// Predicts the uncovered pieces of each item and checks every result beat in order.
// Depends on rsp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
    import rsp_pkg::*;

    localparam int CycleLimit  = 50000;
    localparam int RandomItems = 105;
    localparam int ShownErrors = 10;

    typedef struct {
        logic        overlap;
        logic        piece_valid;
        logic [1:0]  side;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic        last;
    } piece_beat_t;

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    logic signed [15:0] cover_x = '0;
    logic signed [15:0] cover_y = '0;
    logic [14:0]        cover_w = '0;
    logic [14:0]        cover_h = '0;
    logic signed [15:0] area_x  = '0;
    logic signed [15:0] area_y  = '0;
    logic [14:0]        area_w  = '0;
    logic [14:0]        area_h  = '0;
    logic               strobe;
    logic               overlap;
    logic               piece_valid;
    logic [1:0]         piece_side;
    logic signed [15:0] piece_x;
    logic signed [15:0] piece_y;
    logic [14:0]        piece_w;
    logic [14:0]        piece_h;
    logic               last;

    piece_beat_t pending_pieces[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;

    rectangle_subtract_pieces uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cover_x     (cover_x),
        .cover_y     (cover_y),
        .cover_w     (cover_w),
        .cover_h     (cover_h),
        .area_x      (area_x),
        .area_y      (area_y),
        .area_w      (area_w),
        .area_h      (area_h),
        .strobe      (strobe),
        .overlap     (overlap),
        .piece_valid (piece_valid),
        .piece_side  (piece_side),
        .piece_x     (piece_x),
        .piece_y     (piece_y),
        .piece_w     (piece_w),
        .piece_h     (piece_h),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CycleLimit) @(posedge clk);
        $display("[rectangle_subtract_pieces] ERROR");
        $finish;
    end

    function automatic piece_beat_t make_beat(input logic ov, input logic valid,
                                              input logic [1:0] side, input int x,
                                              input int y, input int w, input int h);
        piece_beat_t b;
        b.overlap     = ov;
        b.piece_valid = valid;
        b.side        = side;
        b.x           = x[15:0];
        b.y           = y[15:0];
        b.w           = w[14:0];
        b.h           = h[14:0];
        b.last        = 1'b0;
        return b;
    endfunction

    // Split the area around the cover and queue the uncovered pieces, top to bottom.
    function automatic void predict_pieces(input item_t it);
        int cx, cy, cw, ch, ax, ay, aw, ah;
        int cr, cb, ar, ab, my, mh;
        piece_beat_t found[$];
        piece_beat_t b;
        cx = $signed(it.cover_x);
        cy = $signed(it.cover_y);
        cw = it.cover_w;
        ch = it.cover_h;
        ax = $signed(it.area_x);
        ay = $signed(it.area_y);
        aw = it.area_w;
        ah = it.area_h;
        cr = cx + cw;
        cb = cy + ch;
        ar = ax + aw;
        ab = ay + ah;
        if (!(cx < ar && cr > ax && cy < ab && cb > ay))
        begin
            b = make_beat(1'b0, 1'b1, SIDE_TOP, ax, ay, aw, ah);
            b.last = 1'b1;
            pending_pieces.push_back(b);
            return;
        end
        // rows shared by both rectangles
        my = (cy > ay) ? cy : ay;
        mh = ((cb < ab) ? cb : ab) - my;
        if (cy > ay)
            found.push_back(make_beat(1'b1, 1'b1, SIDE_TOP, ax, ay, aw, cy - ay));
        if (cx > ax)
            found.push_back(make_beat(1'b1, 1'b1, SIDE_LEFT, ax, my, cx - ax, mh));
        if (cr < ar)
            found.push_back(make_beat(1'b1, 1'b1, SIDE_RIGHT, cr, my, ar - cr, mh));
        if (cb < ab)
            found.push_back(make_beat(1'b1, 1'b1, SIDE_BOTTOM, ax, cb, aw, ab - cb));
        if (found.size() == 0)
            found.push_back(make_beat(1'b1, 1'b0, SIDE_TOP, 0, 0, 0, 0));
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            pending_pieces.push_back(found[i]);
    endfunction

    always @(posedge clk)
    begin
        piece_beat_t want;
        if (rst_n && strobe)
        begin
            if (pending_pieces.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ShownErrors)
                    $display("unexpected beat: side=%0d x=%h y=%h w=%h h=%h last=%b",
                             piece_side, piece_x, piece_y, piece_w, piece_h, last);
            end
            else
            begin
                want = pending_pieces.pop_front();
                if (overlap !== want.overlap || piece_valid !== want.piece_valid ||
                    piece_side !== want.side || piece_x !== want.x ||
                    piece_y !== want.y || piece_w !== want.w ||
                    piece_h !== want.h || last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= ShownErrors)
                    begin
                        $display("beat mismatch at %0t", $realtime);
                        $display("  exp ov=%b v=%b side=%0d x=%h y=%h w=%h h=%h last=%b",
                                 want.overlap, want.piece_valid, want.side, want.x,
                                 want.y, want.w, want.h, want.last);
                        $display("  got ov=%b v=%b side=%0d x=%h y=%h w=%h h=%h last=%b",
                                 overlap, piece_valid, piece_side, piece_x, piece_y,
                                 piece_w, piece_h, last);
                    end
                end
            end
        end
    end

    // Bursts of back-to-back commands separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(1, 6);
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
    endtask

    task automatic send_item(input item_t it);
        pace();
        start   <= 1'b1;
        cover_x <= it.cover_x;
        cover_y <= it.cover_y;
        cover_w <= it.cover_w;
        cover_h <= it.cover_h;
        area_x  <= it.area_x;
        area_y  <= it.area_y;
        area_w  <= it.area_w;
        area_h  <= it.area_h;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_pieces(it);
    endtask

    task automatic send_rects(input int cx, input int cy, input int cw, input int ch,
                              input int ax, input int ay, input int aw, input int ah);
        item_t it;
        it.cover_x = cx[15:0];
        it.cover_y = cy[15:0];
        it.cover_w = cw[14:0];
        it.cover_h = ch[14:0];
        it.area_x  = ax[15:0];
        it.area_y  = ay[15:0];
        it.area_w  = aw[14:0];
        it.area_h  = ah[14:0];
        send_item(it);
    endtask

    // Hold off new commands until every expected beat has come out.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic test_disjoint();
        send_rects(50, -50, 10, 10, -50, -50, 100, 100);       // cover touches right edge
        send_rects(-50, -70, 100, 20, -50, -50, 100, 100);     // cover touches top edge
        send_rects(0, 0, 0, 20, -50, -50, 100, 100);           // zero-width cover inside
        send_rects(-60, -60, 200, 200, 0, 0, 30, 0);           // zero-height area
        send_rects(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
    endtask

    // Every mix of top, left, right and bottom pieces, including full cover.
    task automatic test_side_mixes();
        logic [3:0] mix;
        int cx, cy, cr, cb;
        for (int m = 0; m < 16; m++)
        begin
            mix = m[3:0];
            cx = mix[SIDE_LEFT]   ? -40 : -60;
            cr = mix[SIDE_RIGHT]  ?  40 :  60;
            cy = mix[SIDE_TOP]    ? -40 : -60;
            cb = mix[SIDE_BOTTOM] ?  40 :  60;
            send_rects(cx, cy, cr - cx, cb - cy, -50, -50, 100, 100);
        end
    endtask

    task automatic test_range_edges();
        // right and bottom pieces start past the positive range
        send_rects(32700, 32700, 100, 100, 32000, 32000, 32767, 32767);
        send_rects(-32768, -32768, 10, 10, -32768, -32768, 32767, 32767);
        send_rects(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_rects(-32768, -100, 32767, 40, -100, -120, 50, 90);
    endtask

    task automatic test_random();
        item_t it;
        int aw, ah, kind;
        for (int n = 0; n < RandomItems; n++)
        begin
            kind = $urandom_range(0, 9);
            it.area_x = 16'($urandom);
            it.area_y = 16'($urandom);
            aw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
            ah = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
            it.area_w = aw[14:0];
            it.area_h = ah[14:0];
            if (kind < 2)
            begin
                // unrelated rectangles over the full range
                it.cover_x = 16'($urandom);
                it.cover_y = 16'($urandom);
                it.cover_w = 15'($urandom);
                it.cover_h = 15'($urandom);
            end
            else
            begin
                // cover placed around the area so that most items break it
                it.cover_x = 16'(int'(it.area_x) + int'($urandom_range(0, aw + 40)) - 20);
                it.cover_y = 16'(int'(it.area_y) + int'($urandom_range(0, ah + 40)) - 20);
                it.cover_w = 15'($urandom_range(0, aw + 40));
                it.cover_h = 15'($urandom_range(0, ah + 40));
            end
            send_item(it);
            if (n == RandomItems / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disjoint();
        test_side_mixes();
        wait_drained();
        test_range_edges();
        test_random();
        wait_drained();
        if (mismatch_count == 0 && pending_pieces.size() == 0)
            $display("[rectangle_subtract_pieces] OK");
        else
            $display("[rectangle_subtract_pieces] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/rsp_pkg.sv
src/rsp_split.sv
src/rectangle_subtract_pieces.sv
src/rsp_checker.sv
sim/testbench.sv
